[rtl/core/ptp_pkg.sv]
package ptp_pkg;

  // Command codes of the input channel.
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  // Result kinds of the output channel.
  typedef enum logic [2:0] {
    KIND_STARTED = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_ACK     = 3'd2,
    KIND_FIRED   = 3'd3,
    KIND_IDLE    = 3'd4
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Maximum number of firings reported for one tick.
  localparam int MaxResults = 32;
  localparam int CntW       = 6;

  // One timer slot as it travels around the ring.
  typedef struct packed {
    logic        busy;
    logic [15:0] task_id;
    logic [30:0] period;
    logic [31:0] start_time;
    logic [63:0] user_word;
  } slot_rec_t;

endpackage

[rtl/core/ptp_cell.sv]
module ptp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  ptp_pkg::slot_rec_t rec_i,
  output ptp_pkg::slot_rec_t rec_o
);
  import ptp_pkg::*;

  slot_rec_t data_q;

  // The slot record clears at reset and moves one cell toward the head
  // whenever the ring advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= rec_i;
    end
  end

  assign rec_o = data_q;

endmodule

[rtl/core/periodic_timer_pool_unit.sv]
// Pool of periodic timers, one millisecond per tick command.
// Input channel (in_valid_i / in_stall_o) carries a command: start, stop,
// restart or tick. Output channel (out_valid_o / out_stall_i) returns the
// results; last_o marks the final result of each command.
// The slots sit in a ring of cells that rotates once per command: each
// cycle the slot at the head is examined, updated and passed to the tail.
// Each command scans all TIMERS slots and then, in a finish state, loads
// its last result into the output register; a new command is taken only
// after that, so commands do not overlap.
// A tick reports each firing slot in slot order, at most 32 per tick;
// results are held in an output register, and while it is stalled the
// ring stops rotating, so nothing is lost.
// Reset frees every slot, clears the millisecond counter and empties the
// output register; a command may be sent in the first cycle after reset.
module periodic_timer_pool_unit #(
  parameter int TIMERS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [30:0] interval_ms_i,
  input  logic [4:0]  handle_i,
  input  logic [15:0] task_id_i,
  input  logic [63:0] user_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [4:0]  slot_o,
  output logic [15:0] receiver_o,
  output logic [63:0] payload_o,
  output logic        last_o
);
  import ptp_pkg::*;

  localparam int IdxW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  cmd_e              cmd_q;
  logic [30:0]       interval_q;
  logic [4:0]        handle_q;
  logic [15:0]       task_q;
  logic [63:0]       word_q;
  logic [31:0]       now_q, now_d;
  logic              found_q, found_d;
  logic [4:0]        found_slot_q, found_slot_d;
  logic              pend_valid_q, pend_valid_d;
  logic [4:0]        pend_slot_q, pend_slot_d;
  logic [15:0]       pend_task_q, pend_task_d;
  logic [63:0]       pend_word_q, pend_word_d;
  logic [CntW-1:0]   fire_cnt_q, fire_cnt_d;
  logic              out_valid_q;
  kind_e             out_kind_q, out_kind_d;
  logic [4:0]        out_slot_q, out_slot_d;
  logic [15:0]       out_recv_q, out_recv_d;
  logic [63:0]       out_word_q, out_word_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;
  logic              in_take;
  logic              shift;
  logic              hit;
  logic              fire;
  logic [31:0]       elapsed;
  slot_rec_t         head;
  slot_rec_t         head_new;
  slot_rec_t         ring [TIMERS];

  // Ring of slot cells; the updated head record re-enters at the tail.
  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    slot_rec_t cell_in;
    if (i == TIMERS - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_mid
      assign cell_in = ring[i+1];
    end
    ptp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (cell_in),
      .rec_o  (ring[i])
    );
  end

  assign head     = ring[0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = in_valid_i && (state_q == ST_IDLE);
  assign hit      = (7'(handle_q) == 7'(idx_q));
  assign elapsed  = now_q - head.start_time;
  assign fire     = (cmd_q == CMD_TICK) && head.busy && (elapsed > {1'b0, head.period})
                    && (fire_cnt_q < CntW'(MaxResults));

  // Update of the slot at the head of the ring for the current command.
  always_comb begin
    head_new = head;
    case (cmd_q)
      CMD_START: begin
        if (!found_q && !head.busy) begin
          head_new.busy       = 1'b1;
          head_new.task_id    = task_q;
          head_new.period     = interval_q;
          head_new.user_word  = word_q;
          head_new.start_time = now_q;
        end
      end
      CMD_STOP: begin
        if (hit) begin
          head_new = '0;
        end
      end
      CMD_RESTART: begin
        if (hit) begin
          head_new.start_time = now_q;
          if (interval_q != '0) begin
            head_new.period = interval_q;
          end
        end
      end
      default: begin
        if (fire) begin
          head_new.start_time = now_q;
        end
      end
    endcase
  end

  // Sequencer: next state, scan bookkeeping and result generation.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    now_d        = now_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_task_d  = pend_task_q;
    pend_word_d  = pend_word_q;
    fire_cnt_d   = fire_cnt_q;
    shift        = 1'b0;
    out_load     = 1'b0;
    out_kind_d   = KIND_ACK;
    out_slot_d   = '0;
    out_recv_d   = '0;
    out_word_d   = '0;
    out_last_d   = 1'b1;
    in_stall_o   = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          idx_d        = '0;
          found_d      = 1'b0;
          pend_valid_d = 1'b0;
          fire_cnt_d   = '0;
          if (cmd_e'(cmd_i) == CMD_TICK) begin
            now_d = now_q + 32'd1;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          shift = 1'b1;
          if (cmd_q == CMD_START && !found_q && !head.busy) begin
            found_d      = 1'b1;
            found_slot_d = 5'(idx_q);
          end
          if (fire) begin
            // A new firing pushes the previous one out; it is not the last.
            if (pend_valid_q) begin
              out_load   = 1'b1;
              out_kind_d = KIND_FIRED;
              out_slot_d = pend_slot_q;
              out_recv_d = pend_task_q;
              out_word_d = pend_word_q;
              out_last_d = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_slot_d  = 5'(idx_q);
            pend_task_d  = head.task_id;
            pend_word_d  = head.user_word;
            fire_cnt_d   = fire_cnt_q + CntW'(1);
          end
          idx_d = idx_q + IdxW'(1);
          if (idx_q == IdxW'(TIMERS - 1)) begin
            idx_d   = '0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          case (cmd_q)
            CMD_START: begin
              out_kind_d = found_q ? KIND_STARTED : KIND_FULL;
              out_slot_d = found_q ? found_slot_q : '0;
            end
            CMD_TICK: begin
              if (pend_valid_q) begin
                out_kind_d = KIND_FIRED;
                out_slot_d = pend_slot_q;
                out_recv_d = pend_task_q;
                out_word_d = pend_word_q;
              end else begin
                out_kind_d = KIND_IDLE;
              end
            end
            default: begin
              out_kind_d = KIND_ACK;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      now_q        <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      fire_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      now_q        <= now_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      fire_cnt_q   <= fire_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command capture, pending firing and output payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q      <= cmd_e'(cmd_i);
      interval_q <= interval_ms_i;
      handle_q   <= handle_i;
      task_q     <= task_id_i;
      word_q     <= user_data_i;
    end
    found_slot_q <= found_slot_d;
    pend_slot_q  <= pend_slot_d;
    pend_task_q  <= pend_task_d;
    pend_word_q  <= pend_word_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_slot_q <= out_slot_d;
      out_recv_q <= out_recv_d;
      out_word_q <= out_word_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign slot_o      = out_slot_q;
  assign receiver_o  = out_recv_q;
  assign payload_o   = out_word_q;
  assign last_o      = out_last_q;

endmodule
